// ----- hw/rtl/kce_pkg.sv -----
// ----------------------------------------------------------------------------
// kce_pkg
// Shared types, sizes and codes of the k-means cluster engine.
// ----------------------------------------------------------------------------
package kce_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_DIMS     = 8;
  localparam int COORD_W      = 16;

  localparam int PT_IDX_W  = $clog2(MAX_POINTS);
  localparam int CL_IDX_W  = $clog2(MAX_CLUSTERS);
  localparam int DIM_IDX_W = $clog2(MAX_DIMS);
  localparam int PT_ADDR_W = PT_IDX_W + DIM_IDX_W;
  localparam int CT_ADDR_W = CL_IDX_W + DIM_IDX_W;
  localparam int PT_DEPTH  = MAX_POINTS * MAX_DIMS;
  localparam int CT_DEPTH  = MAX_CLUSTERS * MAX_DIMS;

  localparam int NP_W     = 11;
  localparam int NC_W     = 5;
  localparam int ND_W     = 4;
  localparam int ITER_W   = 16;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W     = 3;

  localparam int CNT_W    = PT_IDX_W + 1;
  localparam int SUM_W    = COORD_W + PT_IDX_W;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ_W     = 2 * COORD_W;
  localparam int DIST_W   = SQ_W + DIM_IDX_W;
  localparam int DIV_W    = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [CFG_W-1:0] LFSR_MASK = 32'h8020_0003;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_POINT    = 3'd0,
    OP_LOAD_CENTROID = 3'd1,
    OP_RUN           = 3'd2,
    OP_READ_CLUSTER  = 3'd3,
    OP_READ_CENTROID = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_POINTS   = 3'd0,
    CFG_NUM_CLUSTERS = 3'd1,
    CFG_NUM_DIMS     = 3'd2,
    CFG_MAX_ITER     = 3'd3,
    CFG_THRESHOLD    = 3'd4,
    CFG_SEED         = 3'd5
  } cfg_idx_e;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD_PT,
    DP_LOAD_CT,
    DP_READ_AS,
    DP_READ_CT,
    DP_OUT_CLUSTER,
    DP_OUT_COORD,
    DP_OUT_RUN,
    DP_RUN_INIT,
    DP_COPY,
    DP_CNT_CLR,
    DP_DIST_CLR,
    DP_DIST_RD,
    DP_CONV_RD,
    DP_DIST_SQ,
    DP_DIST_ACC,
    DP_BEST,
    DP_ASSIGN_WR,
    DP_ACC_RD,
    DP_ACC_WR,
    DP_LFSR_STEP,
    DP_DIV_LFSR,
    DP_SUM_RD,
    DP_DIV_SUM,
    DP_RSD_RD,
    DP_CT_WR_PT,
    DP_CT_WR_Q,
    DP_CONV_INIT,
    DP_CONV_CHK
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_AS,
    S_RD_CT,
    S_RUN,
    S_COPY,
    S_COPY_END,
    S_A_CLR,
    S_A_RD,
    S_A_SQ,
    S_A_ACC,
    S_A_BEST,
    S_A_WR,
    S_S_RD,
    S_S_WR,
    S_U_CHK,
    S_U_LDIV,
    S_U_LWAIT,
    S_U_PRD,
    S_U_PWR,
    S_U_SRD,
    S_U_SDIV,
    S_U_SWAIT,
    S_U_SWR,
    S_U_NEXT,
    S_C_CLR,
    S_C_RD,
    S_C_SQ,
    S_C_ACC,
    S_C_CHK,
    S_C_END,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e                op;
    logic [PT_IDX_W-1:0]   pidx;
    logic [CL_IDX_W-1:0]   cidx;
    logic [DIM_IDX_W-1:0]  didx;
    logic [ITER_W-1:0]     iter;
  } dp_cmd_t;

  typedef struct packed {
    logic out_valid;
    logic cnt_zero;
    logic div_busy;
    logic conv;
  } dp_status_t;

endpackage

// ----- hw/rtl/kce_datapath.sv -----
// ----------------------------------------------------------------------------
// kce_datapath
// Point, centroid, previous-centroid, sum and assignment stores, distance unit,
// shared divider, reseed lfsr and result register, driven one command per cycle.
// ----------------------------------------------------------------------------
module kce_datapath import kce_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  output dp_status_t                 status_o,
  input  logic [NP_W-1:0]            num_points_i,
  input  logic [CFG_W-1:0]           threshold_i,
  input  logic                       seed_wr_i,
  input  logic [CFG_W-1:0]           seed_i,
  input  logic [PT_IDX_W-1:0]        item_index_i,
  input  logic [DIM_IDX_W-1:0]       dim_index_i,
  input  logic signed [COORD_W-1:0]  coord_value_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [CL_IDX_W-1:0]        cluster_id_o,
  output logic signed [COORD_W-1:0]  coord_out_o,
  output logic [ITER_W-1:0]          iterations_done_o,
  output logic                       converged_o
);

  logic signed [COORD_W-1:0] pt_mem  [PT_DEPTH];
  logic signed [COORD_W-1:0] ct_mem  [CT_DEPTH];
  logic signed [COORD_W-1:0] pv_mem  [CT_DEPTH];
  logic signed [SUM_W-1:0]   sum_mem [CT_DEPTH];
  logic [CL_IDX_W-1:0]       as_mem  [MAX_POINTS];

  logic signed [COORD_W-1:0] pt_rdata_q, ct_rdata_q, pv_rdata_q;
  logic signed [SUM_W-1:0]   sum_rdata_q;
  logic [CL_IDX_W-1:0]       as_rdata_q;

  logic [PT_ADDR_W-1:0]      pt_raddr;
  logic                      ct_we;
  logic [CT_ADDR_W-1:0]      ct_waddr, ct_raddr;
  logic signed [COORD_W-1:0] ct_wdata;
  logic                      sum_we;
  logic [CT_ADDR_W-1:0]      sum_waddr, sum_raddr;
  logic signed [SUM_W-1:0]   sum_wdata;
  logic [CT_ADDR_W-1:0]      cur_addr;

  logic                      copy_wr_q;
  logic [CT_ADDR_W-1:0]      copy_addr_q;
  logic                      conv_sel_q;
  logic                      oob_q;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [2*DIFF_W-1:0] prod;
  logic [SQ_W-1:0]            sq_q;
  logic [DIST_W-1:0]          acc_q, best_q;
  logic [CL_IDX_W-1:0]        bj_q;
  logic                       conv_q;

  logic [CNT_W-1:0]           cnt_q [MAX_CLUSTERS];
  logic [CFG_W-1:0]           lfsr_q, lfsr_src;

  logic [DIV_W-1:0]           dvd_q;
  logic [CNT_W-1:0]           dvs_q, rem_q;
  logic [DIV_CNT_W-1:0]       div_step_q;
  logic                       div_busy_q;
  logic                       neg_q;
  logic [CNT_W:0]             div_trial;
  logic                       div_bit;
  logic [SUM_W-1:0]           sum_mag;
  logic [COORD_W-1:0]         quo;

  assign cur_addr = {cmd_i.cidx, cmd_i.didx};

  // address and data selection
  always_comb begin
    pt_raddr = {cmd_i.pidx, cmd_i.didx};
    if (cmd_i.op == DP_RSD_RD) begin
      pt_raddr = {rem_q[PT_IDX_W-1:0], cmd_i.didx};
    end

    quo      = dvd_q[COORD_W-1:0];
    ct_we    = 1'b0;
    ct_waddr = cur_addr;
    ct_wdata = pt_rdata_q;
    unique case (cmd_i.op)
      DP_LOAD_PT, DP_READ_AS, DP_READ_CT, DP_OUT_CLUSTER, DP_OUT_COORD, DP_OUT_RUN,
      DP_RUN_INIT, DP_NOP, DP_COPY, DP_CNT_CLR, DP_DIST_CLR, DP_DIST_RD, DP_CONV_RD,
      DP_DIST_SQ, DP_DIST_ACC, DP_BEST, DP_ASSIGN_WR, DP_ACC_RD, DP_ACC_WR,
      DP_LFSR_STEP, DP_DIV_LFSR, DP_SUM_RD, DP_DIV_SUM, DP_RSD_RD, DP_CONV_INIT,
      DP_CONV_CHK: begin
        ct_we = 1'b0;
      end
      DP_LOAD_CT: begin
        ct_we    = (item_index_i[PT_IDX_W-1:CL_IDX_W] == '0);
        ct_waddr = {item_index_i[CL_IDX_W-1:0], dim_index_i};
        ct_wdata = coord_value_i;
      end
      DP_CT_WR_PT: begin
        ct_we = 1'b1;
      end
      DP_CT_WR_Q: begin
        ct_we    = 1'b1;
        ct_wdata = neg_q ? -$signed(quo) : $signed(quo);
      end
      default: ct_we = 1'b0;
    endcase

    ct_raddr = cur_addr;
    if (cmd_i.op == DP_READ_CT) begin
      ct_raddr = {item_index_i[CL_IDX_W-1:0], dim_index_i};
    end

    sum_we    = 1'b0;
    sum_waddr = cur_addr;
    sum_wdata = '0;
    if (cmd_i.op == DP_COPY) begin
      sum_we = 1'b1;
    end else if (cmd_i.op == DP_ACC_WR) begin
      sum_we    = 1'b1;
      sum_waddr = {bj_q, cmd_i.didx};
      sum_wdata = sum_rdata_q + SUM_W'(pt_rdata_q);
    end
    sum_raddr = (cmd_i.op == DP_ACC_RD) ? {bj_q, cmd_i.didx} : cur_addr;

    diff = conv_sel_q ? (DIFF_W'(ct_rdata_q) - DIFF_W'(pv_rdata_q))
                      : (DIFF_W'(ct_rdata_q) - DIFF_W'(pt_rdata_q));
    prod = diff * diff;

    sum_mag = sum_rdata_q[SUM_W-1] ? (-sum_rdata_q) : sum_rdata_q;

    div_trial = {rem_q, dvd_q[DIV_W-1]};
    div_bit   = (div_trial >= {1'b0, dvs_q});

    lfsr_src = (lfsr_q == '0) ? CFG_W'(1) : lfsr_q;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LOAD_PT) begin
      pt_mem[{item_index_i, dim_index_i}] <= coord_value_i;
    end
    pt_rdata_q <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ct_we) begin
      ct_mem[ct_waddr] <= ct_wdata;
    end
    ct_rdata_q <= ct_mem[ct_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (copy_wr_q) begin
      pv_mem[copy_addr_q] <= ct_rdata_q;
    end
    pv_rdata_q <= pv_mem[cur_addr];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_rdata_q <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_ASSIGN_WR) begin
      as_mem[cmd_i.pidx] <= bj_q;
    end
    as_rdata_q <= as_mem[item_index_i];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_wr_q  <= 1'b0;
      conv_sel_q <= 1'b0;
      conv_q     <= 1'b0;
      div_busy_q <= 1'b0;
      div_step_q <= '0;
      lfsr_q     <= CFG_W'(1);
      out_valid_o <= 1'b0;
      for (int k = 0; k < MAX_CLUSTERS; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      copy_wr_q  <= (cmd_i.op == DP_COPY);
      conv_sel_q <= (cmd_i.op == DP_CONV_RD);

      if (cmd_i.op == DP_RUN_INIT) begin
        conv_q <= 1'b0;
      end else if (cmd_i.op == DP_CONV_INIT) begin
        conv_q <= 1'b1;
      end else if (cmd_i.op == DP_CONV_CHK && acc_q > DIST_W'(threshold_i)) begin
        conv_q <= 1'b0;
      end

      if (cmd_i.op == DP_CNT_CLR) begin
        for (int k = 0; k < MAX_CLUSTERS; k++) begin
          cnt_q[k] <= '0;
        end
      end else if (cmd_i.op == DP_ASSIGN_WR) begin
        cnt_q[bj_q] <= cnt_q[bj_q] + CNT_W'(1);
      end

      if (seed_wr_i) begin
        lfsr_q <= seed_i;
      end else if (cmd_i.op == DP_LFSR_STEP) begin
        lfsr_q <= (lfsr_src >> 1) ^ (lfsr_src[0] ? LFSR_MASK : '0);
      end

      if (cmd_i.op == DP_DIV_LFSR || cmd_i.op == DP_DIV_SUM) begin
        div_busy_q <= 1'b1;
        div_step_q <= '0;
      end else if (div_busy_q) begin
        div_step_q <= div_step_q + DIV_CNT_W'(1);
        if (div_step_q == DIV_CNT_W'(DIV_W - 1)) begin
          div_busy_q <= 1'b0;
        end
      end

      if (cmd_i.op == DP_OUT_CLUSTER || cmd_i.op == DP_OUT_COORD ||
          cmd_i.op == DP_OUT_RUN) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // arithmetic and result payload
  always_ff @(posedge clk_i) begin
    copy_addr_q <= cur_addr;
    if (cmd_i.op == DP_READ_CT) begin
      oob_q <= (item_index_i[PT_IDX_W-1:CL_IDX_W] != '0);
    end
    if (cmd_i.op == DP_DIST_SQ) begin
      sq_q <= prod[SQ_W-1:0];
    end
    if (cmd_i.op == DP_DIST_CLR) begin
      acc_q <= '0;
    end else if (cmd_i.op == DP_DIST_ACC) begin
      acc_q <= acc_q + DIST_W'(sq_q);
    end
    if (cmd_i.op == DP_BEST && (cmd_i.cidx == '0 || acc_q < best_q)) begin
      best_q <= acc_q;
      bj_q   <= cmd_i.cidx;
    end

    if (cmd_i.op == DP_DIV_LFSR) begin
      dvd_q <= lfsr_q;
      dvs_q <= CNT_W'(num_points_i);
      rem_q <= '0;
    end else if (cmd_i.op == DP_DIV_SUM) begin
      dvd_q <= DIV_W'(sum_mag);
      dvs_q <= cnt_q[cmd_i.cidx];
      rem_q <= '0;
      neg_q <= sum_rdata_q[SUM_W-1];
    end else if (div_busy_q) begin
      dvd_q <= {dvd_q[DIV_W-2:0], div_bit};
      rem_q <= div_bit ? CNT_W'(div_trial - {1'b0, dvs_q}) : div_trial[CNT_W-1:0];
    end

    unique case (cmd_i.op)
      DP_OUT_CLUSTER: begin
        cluster_id_o      <= as_rdata_q;
        coord_out_o       <= '0;
        iterations_done_o <= '0;
        converged_o       <= 1'b0;
      end
      DP_OUT_COORD: begin
        cluster_id_o      <= '0;
        coord_out_o       <= oob_q ? '0 : ct_rdata_q;
        iterations_done_o <= '0;
        converged_o       <= 1'b0;
      end
      DP_OUT_RUN: begin
        cluster_id_o      <= '0;
        coord_out_o       <= '0;
        iterations_done_o <= cmd_i.iter;
        converged_o       <= conv_q;
      end
      default: begin
      end
    endcase
  end

  assign status_o.out_valid = out_valid_o;
  assign status_o.cnt_zero  = (cnt_q[cmd_i.cidx] == '0);
  assign status_o.div_busy  = div_busy_q;
  assign status_o.conv      = conv_q;

endmodule

// ----- hw/rtl/kce_controller.sv -----
// ----------------------------------------------------------------------------
// kce_controller
// Sequencer of load, read and run words: walks points, clusters and
// coordinates and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module kce_controller import kce_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [NP_W-1:0]    num_points_i,
  input  logic [NC_W-1:0]    num_clusters_i,
  input  logic [ND_W-1:0]    num_dims_i,
  input  logic [ITER_W-1:0]  max_iterations_i,
  input  dp_status_t         status_i,
  output dp_cmd_t            cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [PT_IDX_W-1:0]  pi_q, pi_d;
  logic [CL_IDX_W-1:0]  cj_q, cj_d;
  logic [DIM_IDX_W-1:0] cd_q, cd_d;
  logic [ITER_W-1:0]    it_q, it_d;
  logic last_p, last_c, last_d, accept;

  assign last_p = ({1'b0, pi_q} == num_points_i - NP_W'(1));
  assign last_c = ({1'b0, cj_q} == num_clusters_i - NC_W'(1));
  assign last_d = ({1'b0, cd_q} == num_dims_i - ND_W'(1));
  assign in_ready_o = (state_q == S_IDLE) && !status_i.out_valid;
  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pi_q    <= '0;
      cj_q    <= '0;
      cd_q    <= '0;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      pi_q    <= pi_d;
      cj_q    <= cj_d;
      cd_q    <= cd_d;
      it_q    <= it_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pi_d    = pi_q;
    cj_d    = cj_q;
    cd_d    = cd_q;
    it_d    = it_q;
    cmd_o.op   = DP_NOP;
    cmd_o.pidx = pi_q;
    cmd_o.cidx = cj_q;
    cmd_o.didx = cd_q;
    cmd_o.iter = it_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority case (operation_i)
            OP_LOAD_POINT:    cmd_o.op = DP_LOAD_PT;
            OP_LOAD_CENTROID: cmd_o.op = DP_LOAD_CT;
            OP_RUN: begin
              cmd_o.op = DP_RUN_INIT;
              it_d     = '0;
              state_d  = S_RUN;
            end
            OP_READ_CLUSTER: begin
              cmd_o.op = DP_READ_AS;
              state_d  = S_RD_AS;
            end
            OP_READ_CENTROID: begin
              cmd_o.op = DP_READ_CT;
              state_d  = S_RD_CT;
            end
            default: cmd_o.op = DP_NOP;
          endcase
        end
      end
      S_RD_AS: begin
        cmd_o.op = DP_OUT_CLUSTER;
        state_d  = S_IDLE;
      end
      S_RD_CT: begin
        cmd_o.op = DP_OUT_COORD;
        state_d  = S_IDLE;
      end
      S_RUN: begin
        if (it_q < max_iterations_i) begin
          it_d    = it_q + ITER_W'(1);
          cj_d    = '0;
          cd_d    = '0;
          state_d = S_COPY;
        end else begin
          state_d = S_DONE;
        end
      end
      S_COPY: begin
        cmd_o.op = DP_COPY;
        {cj_d, cd_d} = {cj_q, cd_q} + CT_ADDR_W'(1);
        if ({cj_q, cd_q} == '1) begin
          state_d = S_COPY_END;
        end
      end
      S_COPY_END: begin
        cmd_o.op = DP_CNT_CLR;
        pi_d     = '0;
        cj_d     = '0;
        state_d  = S_A_CLR;
      end
      S_A_CLR: begin
        cmd_o.op = DP_DIST_CLR;
        cd_d     = '0;
        state_d  = S_A_RD;
      end
      S_A_RD: begin
        cmd_o.op = DP_DIST_RD;
        state_d  = S_A_SQ;
      end
      S_A_SQ: begin
        cmd_o.op = DP_DIST_SQ;
        state_d  = S_A_ACC;
      end
      S_A_ACC: begin
        cmd_o.op = DP_DIST_ACC;
        if (last_d) begin
          state_d = S_A_BEST;
        end else begin
          cd_d    = cd_q + DIM_IDX_W'(1);
          state_d = S_A_RD;
        end
      end
      S_A_BEST: begin
        cmd_o.op = DP_BEST;
        if (last_c) begin
          state_d = S_A_WR;
        end else begin
          cj_d    = cj_q + CL_IDX_W'(1);
          state_d = S_A_CLR;
        end
      end
      S_A_WR: begin
        cmd_o.op = DP_ASSIGN_WR;
        cd_d     = '0;
        state_d  = S_S_RD;
      end
      S_S_RD: begin
        cmd_o.op = DP_ACC_RD;
        state_d  = S_S_WR;
      end
      S_S_WR: begin
        cmd_o.op = DP_ACC_WR;
        if (!last_d) begin
          cd_d    = cd_q + DIM_IDX_W'(1);
          state_d = S_S_RD;
        end else if (last_p) begin
          cj_d    = '0;
          state_d = S_U_CHK;
        end else begin
          pi_d    = pi_q + PT_IDX_W'(1);
          cj_d    = '0;
          state_d = S_A_CLR;
        end
      end
      S_U_CHK: begin
        cd_d = '0;
        if (status_i.cnt_zero) begin
          cmd_o.op = DP_LFSR_STEP;
          state_d  = S_U_LDIV;
        end else begin
          state_d = S_U_SRD;
        end
      end
      S_U_LDIV: begin
        cmd_o.op = DP_DIV_LFSR;
        state_d  = S_U_LWAIT;
      end
      S_U_LWAIT: begin
        if (!status_i.div_busy) begin
          state_d = S_U_PRD;
        end
      end
      S_U_PRD: begin
        cmd_o.op = DP_RSD_RD;
        state_d  = S_U_PWR;
      end
      S_U_PWR: begin
        cmd_o.op = DP_CT_WR_PT;
        if (last_d) begin
          state_d = S_U_NEXT;
        end else begin
          cd_d    = cd_q + DIM_IDX_W'(1);
          state_d = S_U_PRD;
        end
      end
      S_U_SRD: begin
        cmd_o.op = DP_SUM_RD;
        state_d  = S_U_SDIV;
      end
      S_U_SDIV: begin
        cmd_o.op = DP_DIV_SUM;
        state_d  = S_U_SWAIT;
      end
      S_U_SWAIT: begin
        if (!status_i.div_busy) begin
          state_d = S_U_SWR;
        end
      end
      S_U_SWR: begin
        cmd_o.op = DP_CT_WR_Q;
        if (last_d) begin
          state_d = S_U_NEXT;
        end else begin
          cd_d    = cd_q + DIM_IDX_W'(1);
          state_d = S_U_SRD;
        end
      end
      S_U_NEXT: begin
        if (last_c) begin
          cmd_o.op = DP_CONV_INIT;
          cj_d     = '0;
          state_d  = S_C_CLR;
        end else begin
          cj_d    = cj_q + CL_IDX_W'(1);
          state_d = S_U_CHK;
        end
      end
      S_C_CLR: begin
        cmd_o.op = DP_DIST_CLR;
        cd_d     = '0;
        state_d  = S_C_RD;
      end
      S_C_RD: begin
        cmd_o.op = DP_CONV_RD;
        state_d  = S_C_SQ;
      end
      S_C_SQ: begin
        cmd_o.op = DP_DIST_SQ;
        state_d  = S_C_ACC;
      end
      S_C_ACC: begin
        cmd_o.op = DP_DIST_ACC;
        if (last_d) begin
          state_d = S_C_CHK;
        end else begin
          cd_d    = cd_q + DIM_IDX_W'(1);
          state_d = S_C_RD;
        end
      end
      S_C_CHK: begin
        cmd_o.op = DP_CONV_CHK;
        if (last_c) begin
          state_d = S_C_END;
        end else begin
          cj_d    = cj_q + CL_IDX_W'(1);
          state_d = S_C_CLR;
        end
      end
      S_C_END: begin
        state_d = status_i.conv ? S_DONE : S_RUN;
      end
      S_DONE: begin
        cmd_o.op = DP_OUT_RUN;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/kmeans_cluster_engine.sv -----
// ----------------------------------------------------------------------------
// kmeans_cluster_engine
// Lloyd k-means clustering engine on signed Q8.8 coordinates.
// ----------------------------------------------------------------------------
// usage
//   in channel: one word per handshake carrying operation, item_index,
//   dim_index and coord_value. load words write a point or centroid
//   coordinate and give no result; read words and the run word give one
//   result word on the out channel.
//   cfg channel: cfg_index_i selects a register, always ready; words are to be
//   taken only while idle, a rule for the user that the block does not enforce.
//   sequence: a load word leaves the block idle and ready; a read word reads
//   its store into a register, then loads the result register and raises
//   out_valid_o. a run uses the shared divider once per centroid coordinate
//   of a non-empty cluster and once per empty cluster, which it reseeds
//   with the point that the lfsr picks.
//   in_ready_o is low while a read or run is in progress or a result waits,
//   so a stalled receiver holds the block; the result register keeps its word.
//   reset: registers take their reset values, lfsr loads 1; stores are
//   undefined until written.
// ----------------------------------------------------------------------------
module kmeans_cluster_engine import kce_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [OP_W-1:0]           operation_i,
  input  logic [PT_IDX_W-1:0]       item_index_i,
  input  logic [DIM_IDX_W-1:0]      dim_index_i,
  input  logic signed [COORD_W-1:0] coord_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [CL_IDX_W-1:0]       cluster_id_o,
  output logic signed [COORD_W-1:0] coord_out_o,
  output logic [ITER_W-1:0]         iterations_done_o,
  output logic                      converged_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i
);

  logic [NP_W-1:0]   num_points_q, np_c;
  logic [NC_W-1:0]   num_clusters_q, nc_c;
  logic [ND_W-1:0]   num_dims_q, nd_c;
  logic [ITER_W-1:0] max_iter_q;
  logic [CFG_W-1:0]  threshold_q;
  logic              cfg_we, seed_wr;
  dp_cmd_t           cmd;
  dp_status_t        status;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign seed_wr     = cfg_we && (cfg_index_i == CFG_SEED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q   <= NP_W'(1);
      num_clusters_q <= NC_W'(1);
      num_dims_q     <= ND_W'(1);
      max_iter_q     <= ITER_W'(100);
      threshold_q    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_NUM_POINTS:   num_points_q   <= cfg_data_i[NP_W-1:0];
        CFG_NUM_CLUSTERS: num_clusters_q <= cfg_data_i[NC_W-1:0];
        CFG_NUM_DIMS:     num_dims_q     <= cfg_data_i[ND_W-1:0];
        CFG_MAX_ITER:     max_iter_q     <= cfg_data_i[ITER_W-1:0];
        CFG_THRESHOLD:    threshold_q    <= cfg_data_i;
        CFG_SEED: begin
        end
        default: begin
        end
      endcase
    end
  end

  // counts in use, clamped to at least one and at most the store sizes
  always_comb begin
    np_c = num_points_q;
    if (num_points_q == '0) np_c = NP_W'(1);
    else if (num_points_q > NP_W'(MAX_POINTS)) np_c = NP_W'(MAX_POINTS);
    nc_c = num_clusters_q;
    if (num_clusters_q == '0) nc_c = NC_W'(1);
    else if (num_clusters_q > NC_W'(MAX_CLUSTERS)) nc_c = NC_W'(MAX_CLUSTERS);
    nd_c = num_dims_q;
    if (num_dims_q == '0) nd_c = ND_W'(1);
    else if (num_dims_q > ND_W'(MAX_DIMS)) nd_c = ND_W'(MAX_DIMS);
  end

  kce_controller u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .num_points_i     (np_c),
    .num_clusters_i   (nc_c),
    .num_dims_i       (nd_c),
    .max_iterations_i (max_iter_q),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  kce_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .num_points_i      (np_c),
    .threshold_i       (threshold_q),
    .seed_wr_i         (seed_wr),
    .seed_i            (cfg_data_i),
    .item_index_i      (item_index_i),
    .dim_index_i       (dim_index_i),
    .coord_value_i     (coord_value_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .cluster_id_o      (cluster_id_o),
    .coord_out_o       (coord_out_o),
    .iterations_done_o (iterations_done_o),
    .converged_o       (converged_o)
  );

endmodule

// ----- hw/rtl/kce_checker.sv -----
// ----------------------------------------------------------------------------
// kce_assertions
// Port-level checks of the k-means cluster engine, bound to the top level.
// ----------------------------------------------------------------------------
module kce_assertions import kce_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [OP_W-1:0]           operation_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [CL_IDX_W-1:0]       cluster_id_o,
  input logic signed [COORD_W-1:0] coord_out_o,
  input logic [ITER_W-1:0]         iterations_done_o,
  input logic                      converged_o
);

  // a held word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(iterations_done_o)
      && $stable(cluster_id_o) && $stable(coord_out_o) && $stable(converged_o))
    else $error("result word changed while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input taken while a result waits");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
      (operation_i == OP_LOAD_POINT || operation_i == OP_LOAD_CENTROID)
      |=> !out_valid_o)
    else $error("load word gave a result");

  a_conv_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && converged_o |-> iterations_done_o != '0)
    else $error("converged without an iteration");

endmodule

bind kmeans_cluster_engine kce_assertions u_kce_assertions (.*);
